// ===== rtl/q2e_pkg.sv =====
// shared types, constants and the arctangent table of the quaternion to euler converter
`default_nettype none
package q2e_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int SQRT_STEPS    = 31;
    localparam int OPW           = 34;
    localparam int AW            = 32;
    localparam int CW            = 36;
    localparam int ZW            = 34;
    localparam int RW            = 62;
    localparam int QDEPTH        = 4;
    localparam int QAW           = 2;
    localparam int DEG_MUL       = 45;

    localparam logic signed [OPW-1:0] UNIT_Q30  = OPW'(1) <<< 30;
    localparam logic signed [ZW-1:0]  HALF_TURN = ZW'(1) <<< 31;
    localparam logic [31:0]           PI_Q30    = 32'hC90FDAA2;

    typedef struct packed {
        logic signed [15:0] q_w;
        logic signed [15:0] q_x;
        logic signed [15:0] q_y;
        logic signed [15:0] q_z;
    } t_q_in;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic               pitch_saturated;
    } t_q_out;

    typedef struct packed {
        logic signed [OPW-1:0] roll_num;
        logic signed [OPW-1:0] roll_den;
        logic signed [OPW-1:0] yaw_num;
        logic signed [OPW-1:0] yaw_den;
        logic signed [AW-1:0]  asin_arg;
        logic                  sat;
    } t_item;

    // atan(2^-i) in binary angle units, 2^32 per turn
    function automatic logic [31:0] atan_units(input int idx);
        logic [31:0] v;
        unique case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            24: v = 32'h00000029;
            25: v = 32'h00000014;
            26: v = 32'h0000000A;
            27: v = 32'h00000005;
            28: v = 32'h00000003;
            29: v = 32'h00000001;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/q2e_front.sv =====
// front end: quaternion products, numerators, denominators and arcsine clamp
`default_nettype none
module q2e_front import q2e_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_q_in i_in_data,
    input  wire logic  i_full,
    output logic       o_push,
    output t_item      o_item
);
    logic r_f_valid;
    logic signed [31:0] r_wx, r_yz, r_wz, r_xy, r_wy, r_zx, r_xx, r_yy, r_zz;
    logic signed [OPW-1:0] arg_raw;

    assign o_in_ready = !r_f_valid || !i_full;
    assign o_push     = r_f_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_f_valid <= 1'b1;
        end else if (o_push) begin
            r_f_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_wx <= i_in_data.q_w * i_in_data.q_x;
            r_yz <= i_in_data.q_y * i_in_data.q_z;
            r_wz <= i_in_data.q_w * i_in_data.q_z;
            r_xy <= i_in_data.q_x * i_in_data.q_y;
            r_wy <= i_in_data.q_w * i_in_data.q_y;
            r_zx <= i_in_data.q_z * i_in_data.q_x;
            r_xx <= i_in_data.q_x * i_in_data.q_x;
            r_yy <= i_in_data.q_y * i_in_data.q_y;
            r_zz <= i_in_data.q_z * i_in_data.q_z;
        end
    end

    assign arg_raw = (OPW'(r_wy) - OPW'(r_zx)) <<< 1;

    always_comb begin
        o_item.roll_num = (OPW'(r_wx) + OPW'(r_yz)) <<< 1;
        o_item.roll_den = UNIT_Q30 - ((OPW'(r_xx) + OPW'(r_yy)) <<< 1);
        o_item.yaw_num  = (OPW'(r_wz) + OPW'(r_xy)) <<< 1;
        o_item.yaw_den  = UNIT_Q30 - ((OPW'(r_yy) + OPW'(r_zz)) <<< 1);
        // clamp the arcsine argument to unit magnitude
        priority if (arg_raw > UNIT_Q30) begin
            o_item.asin_arg = AW'(UNIT_Q30);
            o_item.sat      = 1'b1;
        end else if (arg_raw < -UNIT_Q30) begin
            o_item.asin_arg = AW'(-UNIT_Q30);
            o_item.sat      = 1'b1;
        end else begin
            o_item.asin_arg = AW'(arg_raw);
            o_item.sat      = 1'b0;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/q2e_queue.sv =====
// short queue between front end and back end
`default_nettype none
module q2e_queue import q2e_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_item
);
    t_item r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/q2e_cordic.sv =====
// pipelined vectoring cordic, one stage per iteration, angle in binary units
`default_nettype none
module q2e_cordic import q2e_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic signed [CW-1:0]  i_x,
    input  wire logic signed [CW-1:0]  i_y,
    output logic signed [ZW-1:0]       o_angle
);
    logic signed [CW-1:0] r_x [CORDIC_STAGES+1];
    logic signed [CW-1:0] r_y [CORDIC_STAGES+1];
    logic signed [ZW-1:0] r_z [CORDIC_STAGES+1];
    logic                 r_zero [CORDIC_STAGES+1];

    // pre-rotation by a half turn for the left half plane
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= (i_y >= 0) ? HALF_TURN : -HALF_TURN;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
        localparam logic signed [ZW-1:0] ATAN = ZW'(atan_units(g));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[g+1] <= r_zero[g];
                if (r_y[g] >= 0) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + ATAN;
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - ATAN;
                end
            end
        end
    end

    assign o_angle = r_zero[CORDIC_STAGES] ? '0 : r_z[CORDIC_STAGES];
endmodule
`default_nettype wire

// ===== rtl/q2e_back.sv =====
// back end: square root pipeline, three cordic lanes and angle format conversion
`default_nettype none
module q2e_back import q2e_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_deg,
    input  wire logic  i_q_valid,
    input  wire t_item i_q_item,
    output logic       o_pop,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output t_q_out     o_out_data
);
    localparam int NV = SQRT_STEPS + CORDIC_STAGES + 4;

    logic          adv;
    logic [NV-1:0] r_vld;
    logic          r_out_valid;
    t_q_out        r_out;

    logic [AW-2:0]   arg_mag;
    logic [RW-1:0]   r_sq;
    logic [RW-1:0]   r_v   [SQRT_STEPS+1];
    logic [RW-1:0]   r_res [SQRT_STEPS+1];
    t_item           r_itm [SQRT_STEPS+2];
    logic            r_sat [CORDIC_STAGES+1];
    logic            r_csat;

    logic signed [CW-1:0] lane_x [3];
    logic signed [CW-1:0] lane_y [3];
    logic signed [ZW-1:0] ang    [3];
    logic                 r_neg  [3];
    logic [48:0]          r_hi   [3];
    logic [47:0]          r_lo   [3];
    logic [38:0]          r_dp   [3];
    logic signed [15:0]   res16  [3];

    function automatic logic signed [15:0] sat_angle(input logic neg, input logic [17:0] r);
        logic signed [15:0] s;
        if (neg) begin
            s = (r > 18'd32768) ? 16'sh8000 : 16'(18'd0 - r);
        end else begin
            s = (r > 18'd32767) ? 16'sh7FFF : r[15:0];
        end
        return s;
    endfunction

    assign adv         = !r_out_valid || i_out_ready;
    assign o_pop       = adv && i_q_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_vld       <= {r_vld[NV-2:0], i_q_valid};
            r_out_valid <= r_vld[NV-1];
        end
    end

    // square of the clamped argument, then 1 - a^2 in q.60
    assign arg_mag = i_q_item.asin_arg[AW-1] ? (AW-1)'(-i_q_item.asin_arg)
                                             : i_q_item.asin_arg[AW-2:0];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq     <= RW'(arg_mag) * RW'(arg_mag);
            r_itm[0] <= i_q_item;
            r_v[0]   <= (RW'(1) << 60) - r_sq;
            r_res[0] <= '0;
            r_itm[1] <= r_itm[0];
        end
    end

    // one result bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQRT_STEPS - 1 - k));
        logic [RW-1:0] trial;
        assign trial = r_res[k] + BIT;
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_itm[k+2] <= r_itm[k+1];
                if (r_v[k] >= trial) begin
                    r_v[k+1]   <= r_v[k] - trial;
                    r_res[k+1] <= (r_res[k] >> 1) + BIT;
                end else begin
                    r_v[k+1]   <= r_v[k];
                    r_res[k+1] <= r_res[k] >> 1;
                end
            end
        end
    end

    assign lane_y[0] = CW'(r_itm[SQRT_STEPS+1].roll_num);
    assign lane_x[0] = CW'(r_itm[SQRT_STEPS+1].roll_den);
    assign lane_y[1] = CW'(r_itm[SQRT_STEPS+1].asin_arg);
    assign lane_x[1] = signed'(CW'(r_res[SQRT_STEPS]));
    assign lane_y[2] = CW'(r_itm[SQRT_STEPS+1].yaw_num);
    assign lane_x[2] = CW'(r_itm[SQRT_STEPS+1].yaw_den);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sat[0] <= r_itm[SQRT_STEPS+1].sat;
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                r_sat[i+1] <= r_sat[i];
            end
            r_csat <= r_sat[CORDIC_STAGES];
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic [ZW-1:0] mag_raw;
        logic [32:0]   mag;
        logic [65:0]   rad_sum;
        logic [39:0]   deg_sum;

        q2e_cordic u_cordic (
            .i_clk   (i_clk),
            .i_en    (adv),
            .i_x     (lane_x[l]),
            .i_y     (lane_y[l]),
            .o_angle (ang[l])
        );

        assign mag_raw = (ang[l] < 0) ? unsigned'(-ang[l]) : unsigned'(ang[l]);
        assign mag     = (mag_raw > (ZW'(1) << 32)) ? 33'h1_0000_0000 : mag_raw[32:0];

        // partial products of the radian scale, a constant multiply for degrees
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_neg[l] <= ang[l] < 0;
                r_hi[l]  <= 49'(mag[32:16]) * 49'(PI_Q30);
                r_lo[l]  <= 48'(mag[15:0]) * 48'(PI_Q30);
                r_dp[l]  <= 39'(mag) * 39'(DEG_MUL);
            end
        end

        assign rad_sum  = (66'(r_hi[l]) << 16) + 66'(r_lo[l]) + (66'(1) << 47);
        assign deg_sum  = 40'(r_dp[l]) + (40'(1) << 21);
        assign res16[l] = sat_angle(r_neg[l], i_deg ? deg_sum[39:22] : rad_sum[65:48]);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.roll_angle      <= res16[0];
            r_out.pitch_angle     <= res16[1];
            r_out.yaw_angle       <= res16[2];
            r_out.pitch_saturated <= r_csat;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/quaternion_to_euler_angles.sv =====
// top level of the quaternion to zyx euler angle converter
// throughput: one quaternion per cycle while the output is taken,
// set by the fully unrolled sqrt and cordic pipelines
// the back end stalls as a whole while a result waits; a four-entry queue lets the front run on
// reset: synchronous active low, clears valids, queue pointers and the format bit (radians)
`default_nettype none
module quaternion_to_euler_angles import q2e_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_q_in i_in_data,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output t_q_out     o_out_data,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata
);
    // output format: 0 radians q3.13, 1 degrees q9.7
    logic  r_deg;

    // front to queue
    logic  push;
    logic  full;
    t_item front_item;

    // queue to back
    logic  q_valid;
    logic  pop;
    t_item q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg <= 1'b0;
        end else if (i_cfg_we) begin
            r_deg <= i_cfg_wdata;
        end
    end

    // products, sums and arcsine clamp; one register stage
    q2e_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_full     (full),
        .o_push     (push),
        .o_item     (front_item)
    );

    // decouples the front from back end stalls
    q2e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // square root, three arctangents and format conversion
    q2e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_deg       (r_deg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );
endmodule
`default_nettype wire

// ===== rtl/q2e_checker.sv =====
// port level checks of the quaternion to euler converter and their bind
`default_nettype none
module q2e_checker import q2e_pkg::*; (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    input wire logic   o_out_valid,
    input wire logic   i_out_ready,
    input wire t_q_out o_out_data
);
    // a waiting result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // roll and yaw stay within a half turn in either format
    a_roll_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.roll_angle >= -16'sd25800 &&
                        o_out_data.roll_angle <= 16'sd25800 &&
                        o_out_data.yaw_angle >= -16'sd25800 &&
                        o_out_data.yaw_angle <= 16'sd25800)
        else $error("roll or yaw beyond a half turn");

    // pitch stays within a quarter turn
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.pitch_angle >= -16'sd12900 &&
                        o_out_data.pitch_angle <= 16'sd12900)
        else $error("pitch beyond a quarter turn");
endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (.*);
`default_nettype wire

// ===== tb/quaternion_to_euler_angles_tb.sv =====
// testbench for the quaternion to zyx euler angle converter
`timescale 1ns / 100ps
module quaternion_to_euler_angles_tb;
    import q2e_pkg::*;

    localparam int LATENCY = 53;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_in_valid;
    logic   o_in_ready;
    t_q_in  i_in_data;
    logic   o_out_valid;
    logic   i_out_ready;
    t_q_out o_out_data;
    logic   i_cfg_we;
    logic   i_cfg_wdata;

    // predictor copy of the format register
    logic   deg_mode;
    // expected angles, oldest first
    t_q_out angle_queue[$];
    int     error_count;

    // idle percentages of sender and receiver, and a forced receiver hold-off
    int     send_idle_pct;
    int     recv_idle_pct;
    int     recv_hold_cycles;

    quaternion_to_euler_angles dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("quaternion_to_euler_angles_tb: errors");
        $finish;
    end

    // floor shift for signed values
    function automatic longint floor_shift(longint v, int s);
        if (v >= 0) return v >>> s;
        return ~((~v) >>> s);
    endfunction

    function automatic logic [31:0] atan_table(int i);
        logic [31:0] t[32];
        t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
              32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
              32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
              32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
              32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
              32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
              32'h00000001, 32'h00000000};
        return t[i];
    endfunction

    // vectoring cordic, result in binary angle units (2^32 per turn)
    function automatic longint vector_angle(longint y, longint x);
        longint acc;
        longint xs;
        longint ys;
        acc = 0;
        if (x == 0 && y == 0) return 0;
        // negative x: pre-rotate by a half turn
        if (x < 0) begin
            acc = (y >= 0) ? 64'sd2147483648 : -64'sd2147483648;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                acc = acc + longint'(atan_table(i));
            end else begin
                x = x - ys;
                y = y + xs;
                acc = acc - longint'(atan_table(i));
            end
        end
        return acc;
    endfunction

    // floor square root of a 61-bit value
    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // angle units to q3.13 radians or q9.7 degrees, round half away, saturate
    function automatic logic signed [15:0] units_to_angle(longint units);
        logic            neg;
        logic [127:0]    mag;
        logic [127:0]    r;
        neg = units < 0;
        mag = neg ? 128'(-units) : 128'(units);
        if (mag > (128'd1 << 32)) mag = 128'd1 << 32;
        if (deg_mode)
            r = (mag * DEG_MUL + (128'd1 << 21)) >> 22;
        else
            r = (mag * PI_Q30 + (128'd1 << 47)) >> 48;
        if (neg) begin
            if (r > 32768) r = 32768;
            return 16'(-longint'(r));
        end
        if (r > 32767) r = 32767;
        return 16'(r);
    endfunction

    function automatic t_q_out euler_of(t_q_in q);
        t_q_out res;
        longint w, x, y, z, arg, cosv;
        longint unit;
        unit = 64'sd1 << 30;
        w = q.q_w; x = q.q_x; y = q.q_y; z = q.q_z;
        arg = 2 * (w * y - z * x);
        res.pitch_saturated = 1'b0;
        // arcsine clamp
        if (arg > unit) begin
            arg = unit;
            res.pitch_saturated = 1'b1;
        end else if (arg < -unit) begin
            arg = -unit;
            res.pitch_saturated = 1'b1;
        end
        cosv = longint'(floor_sqrt((64'd1 << 60) - longint'(arg * arg)));
        res.roll_angle  = units_to_angle(vector_angle(2 * (w * x + y * z),
                                                     unit - 2 * (x * x + y * y)));
        res.pitch_angle = units_to_angle(vector_angle(arg, cosv));
        res.yaw_angle   = units_to_angle(vector_angle(2 * (w * z + x * y),
                                                     unit - 2 * (y * y + z * z)));
        return res;
    endfunction

    // sends one quaternion, predicting at the transfer; valid stays up until
    // the next idle cycle or drain
    task automatic send_quat(t_q_in q);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= q;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        angle_queue.push_back(euler_of(q));
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (angle_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // only called once the block is idle
    task automatic write_format(logic deg);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= deg;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        deg_mode = deg;
    endtask

    function automatic t_q_in rand_quat();
        t_q_in q;
        q = {$urandom, $urandom};
        return q;
    endfunction

    // near-unit quaternion: the case that matters in practice
    function automatic t_q_in unit_quat();
        t_q_in q;
        int a, b, c;
        a = $urandom_range(23000) - 11500;
        b = $urandom_range(23000) - 11500;
        c = $urandom_range(23000) - 11500;
        q.q_x = 16'(a); q.q_y = 16'(b); q.q_z = 16'(c);
        q.q_w = 16'(($urandom_range(1) ? 1 : -1) *
                int'($sqrt(1073741824.0 - real'(a * a + b * b + c * c)) - 1.0));
        return q;
    endfunction

    task automatic test_directed;
        t_q_in q;
        // identity, both extremes of every field, sign mix
        send_quat('{16'sh7FFF, 16'sh0, 16'sh0, 16'sh0});
        send_quat('{16'sh0, 16'sh0, 16'sh0, 16'sh0});     // zero quaternion
        send_quat('{16'sh0, 16'sh4000, 16'sh4000, 16'sh0});  // roll operands both zero
        send_quat('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
        send_quat('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
        send_quat('{16'sh7FFF, 16'sh0, 16'sh7FFF, 16'sh0});  // arcsine clamp high
        send_quat('{16'sh7FFF, 16'sh0, 16'sh8000, 16'sh0});  // arcsine clamp low
        send_quat('{16'sh5A82, 16'sh0, 16'sh5A82, 16'sh0});  // pitch near +90
        send_quat('{16'sh0, 16'sh7FFF, 16'sh0, 16'sh0});     // negative x operand
        send_quat('{16'sh0, 16'sh8000, 16'sh0, 16'sh0});
        send_quat('{16'sh0, 16'sh0, 16'sh0, 16'sh7FFF});
        send_quat('{16'sh0, 16'sh0, 16'sh0, 16'sh8000});
        send_quat('{16'sh0, 16'sh5A82, 16'sh5A82, 16'sh0});
        send_quat('{16'sh1, 16'shFFFF, 16'sh1, 16'shFFFF});
        send_quat('{16'sh4000, 16'shC000, 16'sh4000, 16'shC000});
        for (int i = 0; i < 6; i++) begin
            q = rand_quat();
            send_quat(q);
        end
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_quat(($urandom_range(99) < 70) ? unit_quat() : rand_quat());
    endtask

    // receiver holds off long enough to fill the queue and stall the input
    task automatic test_backpressure;
        recv_hold_cycles = 200;
        test_random(120);
        drain();
    endtask

    // checks each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (angle_queue.size() == 0) begin
                $display("%0t: result with none expected, actual %h", $time, o_out_data);
                error_count++;
            end else begin
                if (o_out_data !== angle_queue[0])
                    $display("%0t: mismatch expected roll %0d pitch %0d yaw %0d sat %b, %s",
                             $time, angle_queue[0].roll_angle, angle_queue[0].pitch_angle,
                             angle_queue[0].yaw_angle, angle_queue[0].pitch_saturated,
                             $sformatf("actual roll %0d pitch %0d yaw %0d sat %b",
                                       o_out_data.roll_angle, o_out_data.pitch_angle,
                                       o_out_data.yaw_angle, o_out_data.pitch_saturated));
                if (o_out_data !== angle_queue[0]) error_count++;
                void'(angle_queue.pop_front());
            end
        end
    end

    // receiver ready pattern
    always @(posedge i_clk) begin
        if (recv_hold_cycles > 0) begin
            recv_hold_cycles <= recv_hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        error_count = 0;
        deg_mode = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold_cycles = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // radians from reset
        send_idle_pct = 30; recv_idle_pct = 57;
        test_directed();
        drain();
        write_format(1'b1);
        test_directed();
        test_random(300);
        drain();
        write_format(1'b0);
        send_idle_pct = 57; recv_idle_pct = 30;
        test_random(400);
        drain();                       // sender pauses until every result is in
        write_format(1'b1);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(400);
        test_backpressure();
        write_format(1'b0);
        test_random(590);
        drain();

        if (error_count == 0)
            $display("quaternion_to_euler_angles_tb: clean");
        else
            $display("quaternion_to_euler_angles_tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/q2e_pkg.sv
rtl/q2e_front.sv
rtl/q2e_queue.sv
rtl/q2e_cordic.sv
rtl/q2e_back.sv
rtl/quaternion_to_euler_angles.sv
rtl/q2e_checker.sv
tb/quaternion_to_euler_angles_tb.sv
